// ===== rtl/core/lpht_pkg.sv =====
`default_nettype none
package lpht_pkg;

  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpht_front.sv =====
`default_nettype none
module lpht_front #(
  parameter int TABLE_SIZE = 32,
  parameter int IDX_W      = 5
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire                   q_full,
  input  lpht_pkg::in_item_t    in_item,
  output logic                  busy,
  output logic                  q_push,
  output lpht_pkg::in_item_t    q_item,
  output logic [IDX_W-1:0]      q_home
);

  // floor(2^32 / TABLE_SIZE): the quotient estimate is exact or one short
  localparam longint unsigned RECIP_L = (64'd1 << 32) / TABLE_SIZE;
  localparam logic [31:0]     RECIP   = RECIP_L[31:0];
  localparam logic [IDX_W:0]  MOD_LOW = (IDX_W+1)'(TABLE_SIZE);

  logic                          active_r, active_nxt;
  logic                          fix_r, fix_nxt;
  lpht_pkg::in_item_t            item_r, item_nxt;
  logic [lpht_pkg::KEY_W-1:0]    quo_r, quo_nxt;
  logic [lpht_pkg::KEY_W+31:0]   prod;
  logic [IDX_W:0]                est;

  assign busy   = active_r | q_full;
  assign q_item = item_r;

  // first cycle: quotient estimate by reciprocal multiply
  assign prod = {32'd0, item_r.key} * {31'd0, RECIP};

  // second cycle: key - quo * TABLE_SIZE lies in [0, 2*TABLE_SIZE), low bits suffice
  assign est = item_r.key[IDX_W:0] - quo_r[IDX_W:0] * MOD_LOW;

  always_comb begin
    active_nxt = active_r;
    fix_nxt    = fix_r;
    item_nxt   = item_r;
    quo_nxt    = quo_r;
    q_push     = 1'b0;
    q_home     = '0;
    if (active_r) begin
      if (!fix_r) begin
        quo_nxt = prod[lpht_pkg::KEY_W+31:32];
        fix_nxt = 1'b1;
      end else begin
        q_push     = 1'b1;
        q_home     = (est >= MOD_LOW) ? IDX_W'(est - MOD_LOW) : IDX_W'(est);
        active_nxt = 1'b0;
      end
    end else if (start && !busy) begin
      active_nxt = 1'b1;
      fix_nxt    = 1'b0;
      item_nxt   = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    fix_r  <= fix_nxt;
    item_r <= item_nxt;
    quo_r  <= quo_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/lpht_queue.sv =====
`default_nettype none
module lpht_queue #(
  parameter int IDX_W = 5
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  lpht_pkg::in_item_t    push_item,
  input  wire [IDX_W-1:0]       push_home,
  input  wire                   pop,
  output logic                  full,
  output logic                  not_empty,
  output lpht_pkg::in_item_t    pop_item,
  output logic [IDX_W-1:0]      pop_home
);

  lpht_pkg::in_item_t    item_r [2];
  logic [IDX_W-1:0]      home_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = item_r[rd_ptr_r];
  assign pop_home  = home_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      item_r[wr_ptr_r] <= push_item;
      home_r[wr_ptr_r] <= push_home;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lpht_back.sv =====
`default_nettype none
module lpht_back #(
  parameter int TABLE_SIZE = 32,
  parameter int IDX_W      = 5
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  input  lpht_pkg::in_item_t    q_item,
  input  wire [IDX_W-1:0]       q_home,
  output logic                  q_pop,
  output logic                  out_valid,
  output lpht_pkg::out_item_t   out_item
);

  localparam int CNT_W = $clog2(TABLE_SIZE + 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic                        op_r, op_nxt;
  logic [lpht_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lpht_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]            iss_idx_r, iss_idx_nxt;
  logic [CNT_W-1:0]            iss_cnt_r, iss_cnt_nxt;
  logic [IDX_W-1:0]            chk_idx_r, chk_idx_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic                        chk_last_r, chk_last_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lpht_pkg::out_item_t         out_item_r, out_item_nxt;

  logic                        occ_mem [TABLE_SIZE];
  logic [lpht_pkg::KEY_W-1:0]  key_mem [TABLE_SIZE];
  logic [lpht_pkg::VALUE_W-1:0] val_mem [TABLE_SIZE];
  logic                        occ_rd_r;
  logic [lpht_pkg::KEY_W-1:0]  key_rd_r;

  logic                        mem_we;
  logic                        mem_occ_wd;
  logic [IDX_W-1:0]            mem_wa;
  logic                        hit;
  logic [IDX_W-1:0]            iss_idx_inc;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign iss_idx_inc = (iss_idx_r == IDX_W'(TABLE_SIZE - 1)) ? '0 : iss_idx_r + 1'b1;

  assign hit = chk_vld_r &&
               ((op_r == lpht_pkg::REQ_INSERT) ? !occ_rd_r
                                               : (occ_rd_r && key_rd_r == key_r));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    iss_idx_nxt   = iss_idx_r;
    iss_cnt_nxt   = iss_cnt_r;
    chk_idx_nxt   = chk_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_last_nxt  = chk_last_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_occ_wd    = 1'b0;
    mem_wa        = chk_idx_r;
    unique case (state_r)
      ST_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = iss_idx_r;
        iss_idx_nxt = iss_idx_inc;
        if (iss_idx_r == IDX_W'(TABLE_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          op_nxt = q_item.req_type;
          key_nxt = q_item.key;
          val_nxt = q_item.value;
          if ((q_item.req_type == lpht_pkg::REQ_INSERT && cnt_r == CNT_W'(TABLE_SIZE)) ||
              (q_item.req_type == lpht_pkg::REQ_REMOVE && cnt_r == '0)) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: lpht_pkg::STATUS_FAIL, slot: '0,
                              entry_count: lpht_pkg::COUNT_W'(cnt_r)};
          end else begin
            state_nxt   = ST_SCAN;
            iss_idx_nxt = (q_item.req_type == lpht_pkg::REQ_INSERT) ? q_home : '0;
            iss_cnt_nxt = '0;
            chk_vld_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          mem_we        = 1'b1;
          mem_occ_wd    = (op_r == lpht_pkg::REQ_INSERT);
          cnt_nxt       = (op_r == lpht_pkg::REQ_INSERT) ? cnt_r + 1'b1 : cnt_r - 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: lpht_pkg::STATUS_OK,
                            slot: lpht_pkg::SLOT_W'(chk_idx_r),
                            entry_count: lpht_pkg::COUNT_W'(cnt_nxt)};
          state_nxt     = ST_IDLE;
        end else if (chk_vld_r && chk_last_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: lpht_pkg::STATUS_FAIL, slot: '0,
                            entry_count: lpht_pkg::COUNT_W'(cnt_r)};
          state_nxt     = ST_IDLE;
        end else begin
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = iss_idx_r;
          chk_last_nxt = (iss_cnt_r == CNT_W'(TABLE_SIZE - 1));
          iss_idx_nxt  = iss_idx_inc;
          iss_cnt_nxt  = iss_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      iss_idx_r   <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_idx_r   <= iss_idx_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    chk_last_r <= chk_last_nxt;
    out_item_r <= out_item_nxt;
  end

  // slot stores, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_wa] <= mem_occ_wd;
      key_mem[mem_wa] <= key_r;
      val_mem[mem_wa] <= val_r;
    end
    occ_rd_r <= occ_mem[iss_idx_r];
    key_rd_r <= key_mem[iss_idx_r];
  end

endmodule
`default_nettype wire

// ===== rtl/core/linear_probe_hash_table_core.sv =====
`default_nettype none
// linear probing hash table, TABLE_SIZE slots of 31-bit key and 32-bit value
// request channel: in_item is taken at a clock edge with start high and busy low
//   req_type insert places the entry in the first free slot from key mod TABLE_SIZE
//   req_type remove clears the lowest slot holding the key
// result channel: out_valid strobes for one cycle with out_item (status, slot,
//   entry_count); the receiver cannot stall, every beat is taken as it comes
// flow: the front finds the home slot by reciprocal multiply, then one correcting
//   subtract; a two-entry queue hands the request to the back, which walks the
//   slot stores with one registered read per cycle; an immediate full/empty
//   failure gives its result beat without a scan, while a scan checks at most
//   TABLE_SIZE slots
// overlap: front and back work side by side, so a steady stream is paced by the
//   back's one-slot-per-cycle walk
// reset: synchronous, active low; afterwards the back runs a clearing pass over
//   the occupied store before the first request is served, and requests may still
//   be accepted into the front and queue meanwhile
module linear_probe_hash_table_core #(
  parameter int TABLE_SIZE = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  lpht_pkg::in_item_t    in_item,
  output logic                  out_valid,
  output lpht_pkg::out_item_t   out_item
);

  localparam int IDX_W = $clog2(TABLE_SIZE);

  // front to queue
  logic                  fq_push;
  lpht_pkg::in_item_t    fq_item;
  logic [IDX_W-1:0]      fq_home;
  logic                  q_full;

  // queue to back
  logic                  qb_valid;
  lpht_pkg::in_item_t    qb_item;
  logic [IDX_W-1:0]      qb_home;
  logic                  qb_pop;

  // hash front: takes the beat and works out the home slot
  lpht_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .q_full  (q_full),
    .in_item (in_item),
    .busy    (busy),
    .q_push  (fq_push),
    .q_item  (fq_item),
    .q_home  (fq_home)
  );

  // decoupling queue between hashing and table walk
  lpht_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .push_home (fq_home),
    .pop       (qb_pop),
    .full      (q_full),
    .not_empty (qb_valid),
    .pop_item  (qb_item),
    .pop_home  (qb_home)
  );

  // table walk: probe or key scan, store update, result beat
  lpht_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_item    (qb_item),
    .q_home    (qb_home),
    .q_pop     (qb_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== sim/lpht_checker.sv =====
`default_nettype none
module lpht_checker
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  wire        busy,
  input  in_item_t   in_item,
  input  wire        out_valid,
  input  out_item_t  out_item,
  output int         fail_count,
  output int         open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the table, keys only: values never reach the result
  logic [KEY_W-1:0] slot_key [TABLE_SIZE];
  logic             slot_used [TABLE_SIZE];
  int               used_count;
  out_item_t        awaited_q [$];

  initial begin
    fail_count = 0;
    open_count = 0;
    used_count = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, seen, wanted);
    fail_count++;
  endtask

  // applies one request to the shadow table and returns the result beat it yields
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t res;
    int        home;
    int        idx;
    int        n;
    logic      done;
    res.status      = STATUS_FAIL;
    res.slot        = '0;
    res.entry_count = '0;
    done            = 1'b0;
    if (req.req_type == REQ_INSERT) begin
      if (used_count < TABLE_SIZE) begin
        home = int'(req.key % TABLE_SIZE);
        for (n = 0; n < TABLE_SIZE && !done; n++) begin
          idx = (home + n) % TABLE_SIZE;
          if (!slot_used[idx]) begin
            slot_used[idx] = 1'b1;
            slot_key[idx]  = req.key;
            used_count++;
            res.status = STATUS_OK;
            res.slot   = idx[SLOT_W-1:0];
            done       = 1'b1;
          end
        end
      end
    end else if (used_count > 0) begin
      // lowest matching slot wins, duplicates stay behind
      for (n = 0; n < TABLE_SIZE && !done; n++) begin
        if (slot_used[n] && slot_key[n] == req.key) begin
          slot_used[n] = 1'b0;
          slot_key[n]  = '0;
          used_count--;
          res.status = STATUS_OK;
          res.slot   = n[SLOT_W-1:0];
          done       = 1'b1;
        end
      end
    end
    res.entry_count = used_count[COUNT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_used[i] = 1'b0;
      end
      used_count = 0;
      awaited_q.delete();
    end else begin
      // result first: a beat leaving now always belongs to an older request
      if (out_valid === 1'b1) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result beat with no request outstanding", out_item, 0);
        end else begin
          want = awaited_q.pop_front();
          if (out_item.status !== want.status) begin
            report_mismatch("status", out_item.status, want.status);
          end
          if (out_item.slot !== want.slot) begin
            report_mismatch("slot", out_item.slot, want.slot);
          end
          if (out_item.entry_count !== want.entry_count) begin
            report_mismatch("entry_count", out_item.entry_count, want.entry_count);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_q.push_back(apply_request(in_item));
      end
    end
    open_count = awaited_q.size();
  end

endmodule
`default_nettype wire

// ===== sim/tb_linear_probe_hash_table_core.sv =====
`default_nettype none
module tb_linear_probe_hash_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam int TABLE_SIZE   = 32;
  // random request beats after the directed opening
  localparam int RANDOM_BEATS = 650;
  // ~700 beats at their slowest (longest idle gap plus a full scan) and the
  // clearing pass after reset fit in this limit with plenty of margin
  localparam int CYCLE_LIMIT  = 400000;
  // front hash plus full scan, with some slack for stray beats
  localparam int TAIL_CYCLES  = 80;
  // remembered keys for removes, oldest dropped beyond this
  localparam int KEY_POOL_MAX = 48;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        open_count;
  int        cycle_count = 0;
  // idle gap ceiling for the current stretch, 0 means back to back
  int        max_gap = 16;
  // keys sent with inserts, picked from for removes so they mostly hit
  logic [KEY_W-1:0] key_pool [$];

  initial begin
    forever #5 clk = ~clk;
  end

  linear_probe_hash_table_core #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // prediction and comparison live in the checker, the top only drives
  lpht_checker #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // random key: a quarter are small (0..100), of the rest half get their home
  // slot squeezed into 0..3 so that probe chains form and wrap past the top slot
  function automatic logic [KEY_W-1:0] draw_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      k = KEY_W'($urandom_range(0, 100));
    end else if ($urandom_range(0, 1) == 1) begin
      k[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 3));
    end
    return k;
  endfunction

  // one request beat: optional idle gap, then hold start until busy is low
  // at an edge; start stays high when the next beat follows with no gap
  task automatic issue_request(input logic req_kind, input logic [KEY_W-1:0] req_key,
                               input logic [VALUE_W-1:0] req_value);
    int gap;
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_item.req_type <= req_kind;
    in_item.key      <= req_key;
    in_item.value    <= req_value;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (req_kind == REQ_INSERT) begin
      key_pool.push_back(req_key);
      if (key_pool.size() > KEY_POOL_MAX) begin
        void'(key_pool.pop_front());
      end
    end
  endtask

  initial begin : stimulus
    int               beat;
    int               phase_left;
    int               insert_pct;
    int               pick;
    logic [KEY_W-1:0] k;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening
    issue_request(REQ_REMOVE, '0, '0);                    // remove from empty table
    issue_request(REQ_INSERT, '0, '0);                    // home slot 0
    issue_request(REQ_INSERT, '1, '1);                    // largest key, home on top slot
    issue_request(REQ_INSERT, 31'd32, 32'h5555_5555);     // collides at 0, lands on 1
    issue_request(REQ_INSERT, 31'd63, 32'haaaa_aaaa);     // top slot taken, wraps to 2
    issue_request(REQ_INSERT, '0, 32'h1234_5678);         // duplicate key, goes to 3
    issue_request(REQ_REMOVE, 31'd5, '0);                 // key absent
    issue_request(REQ_REMOVE, '0, 32'hdead_beef);         // lowest duplicate first
    issue_request(REQ_REMOVE, '0, '0);                    // then the other one
    issue_request(REQ_REMOVE, '1, '0);
    issue_request(REQ_INSERT, 31'h2aaa_aaaa, 32'h0f0f_0f0f);
    issue_request(REQ_REMOVE, 31'd63, '0);
    issue_request(REQ_REMOVE, 31'd32, '0);
    issue_request(REQ_REMOVE, 31'h2aaa_aaaa, '0);         // table empty again
    issue_request(REQ_REMOVE, '1, '0);                    // remove from empty once more
    issue_request(REQ_INSERT, 31'h5555_5555, '0);

    // random part in phases: filling runs the table to full and past it,
    // draining empties it, mixed wanders around the middle
    phase_left = 50;
    insert_pct = 90;
    max_gap    = 16;
    for (beat = 0; beat < RANDOM_BEATS; beat++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 50);
        case ($urandom_range(0, 2))
          0:       insert_pct = 90;
          1:       insert_pct = 10;
          default: insert_pct = 50;
        endcase
        // some stretches run back to back with no idling
        max_gap = ($urandom_range(0, 3) == 0) ? 0 : 16;
      end
      phase_left--;
      if ($urandom_range(1, 100) <= insert_pct) begin
        // occasional reinsert of a live key for duplicates
        if (key_pool.size() > 0 && $urandom_range(0, 9) == 0) begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else begin
          k = draw_key();
        end
        issue_request(REQ_INSERT, k, $urandom);
      end else begin
        // mostly keys that were inserted, the rest likely absent
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, key_pool.size() - 1);
          k    = key_pool[pick];
          key_pool.delete(pick);
        end else begin
          k = draw_key();
        end
        issue_request(REQ_REMOVE, k, $urandom);
      end
    end
    start <= 1'b0;

    // let the checker see the last accepted beat, then drain
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && open_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
